// ===== rtl/core/pfr_pkg.sv =====
// shared constants and types for the page frame replacement block
package pfr_pkg;

	localparam int MAX_FRAMES = 16;
	localparam int PAGE_BITS  = 16;

	localparam int CFG_DATA_W  = 5;
	localparam int CFG_INDEX_W = 1;
	localparam int FAULT_W     = 32;
	localparam int OUTCOME_W   = 2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_POLICY_MODE   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_IN_USE = 1'd1;

	// policy codes, the unused code behaves as fifo
	localparam logic [1:0] MODE_FIFO  = 2'd0;
	localparam logic [1:0] MODE_LRU   = 2'd1;
	localparam logic [1:0] MODE_CLOCK = 2'd2;

	// result outcome codes
	localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_FAULT = 2'd2;

	localparam logic [CFG_DATA_W-1:0] FRAMES_RESET = 5'd16;

	// commands broadcast from the controller to every frame cell
	typedef struct packed {
		logic commit;     // apply the reference: touch recency, set ref bit
		logic load;       // write the new page into the selected cell
		logic hand_adv;   // hand moves one cell on
		logic hand_home;  // hand beyond the occupied frames returns to frame 0
		logic sweep;      // one second chance step of the clock hand
	} pfr_cell_ctl_t;

	// status of one frame cell
	typedef struct packed {
		logic match;
		logic lru_hit;
		logic token;
		logic ref_bit;
		logic give_next;
		logic give_home;
	} pfr_cell_sts_t;

endpackage

// ===== rtl/core/pfr_encode.sv =====
// one-hot to binary index encoder
module pfr_encode #(
	parameter int N = 16,
	parameter int W = 4
) (
	input  logic [N-1:0] onehot,
	output logic [W-1:0] index
);

	always_comb begin
		index = '0;
		for (int i = 0; i < N; i++) begin
			if (onehot[i]) begin
				index = index | W'(i);
			end
		end
	end

endmodule

// ===== rtl/core/pfr_cell.sv =====
// one page frame: page, recency rank, reference bit and its share of the hand
module pfr_cell #(
	parameter int INDEX     = 0,
	parameter int PAGE_BITS = pfr_pkg::PAGE_BITS,
	parameter int SLOT_W    = 4,
	parameter int CNT_W     = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pfr_pkg::pfr_cell_ctl_t ctl,
	input  logic [PAGE_BITS-1:0]  page,
	input  logic                  sel,
	input  logic [SLOT_W-1:0]     old_rank,
	input  logic [SLOT_W-1:0]     last_rank,
	input  logic [CNT_W-1:0]      filled,
	input  logic [CNT_W-1:0]      wrap,
	input  logic                  from_prev,
	input  logic                  home_any,
	output pfr_pkg::pfr_cell_sts_t sts,
	output logic [PAGE_BITS-1:0]  page_out,
	output logic [SLOT_W-1:0]     rank_out
);

	localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(INDEX);
	localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(INDEX + 1);
	localparam bit               IS_FIRST = (INDEX == 0);

	logic [PAGE_BITS-1:0] page_q;
	logic [SLOT_W-1:0]    rank_q;
	logic                 ref_q;
	logic                 token_q;
	logic                 occupied;
	logic                 move;
	logic                 give_next;
	logic                 give_home;
	logic                 gain;

	assign occupied  = MY_IDX < filled;
	assign move      = ctl.hand_adv || (ctl.sweep && ref_q);
	assign give_next = token_q && move && (NEXT_IDX < wrap);
	assign give_home = token_q && ((move && !(NEXT_IDX < wrap)) || (ctl.hand_home && !occupied));
	assign gain      = from_prev || (IS_FIRST && home_any);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q   <= 1'b0;
			token_q <= IS_FIRST;
		end else begin
			if (ctl.commit && sel) begin
				ref_q <= 1'b1;
			end else if (ctl.sweep && token_q) begin
				ref_q <= 1'b0;
			end
			if (gain) begin
				token_q <= 1'b1;
			end else if (give_next || give_home) begin
				token_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			if (sel) begin
				rank_q <= '0;
				if (ctl.load) begin
					page_q <= page;
				end
			end else if (occupied && rank_q < old_rank) begin
				// frames newer than the touched one age by one
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	assign sts.match     = occupied && (page_q == page);
	assign sts.lru_hit   = occupied && (rank_q == last_rank);
	assign sts.token     = token_q;
	assign sts.ref_bit   = ref_q;
	assign sts.give_next = give_next;
	assign sts.give_home = give_home;
	assign page_out      = page_q;
	assign rank_out      = rank_q;

endmodule

// ===== rtl/core/page_frame_replacement.sv =====
// top level of the page frame replacement block: controller and row of frame cells
//
// One page reference enters on the input channel (in_valid/in_ready, page_number)
// and one result leaves on the output channel (out_valid/out_ready: outcome,
// frame_slot, evicted_page, fault_total). The frames sit in a row of cells that
// compare the page in parallel; the clock hand is a token handed cell to cell.
// A hit or a fill passes the lookup, decision and commit steps after the input
// transfer; the commit step registers the result. A fault adds nothing in fifo
// and lru mode; in clock mode a sweep step before the commit walks the hand one
// frame per cycle until it rests on a frame without a second chance. The next
// reference is taken while a result still waits in the output register; the
// commit step holds until that register is free, so a stalled receiver stops
// the block after at most one more reference. Reset empties all frames, clears
// the reference bits, puts the hand on frame 0, zeroes the fault count and
// selects fifo with 16 frames. The user must use the configuration write port
// (cfg_we, cfg_index, cfg_data) only while the block is idle; it is unchecked.
module page_frame_replacement #(
	parameter int MAX_FRAMES = pfr_pkg::MAX_FRAMES,
	parameter int PAGE_BITS  = pfr_pkg::PAGE_BITS,
	localparam int SLOT_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
	localparam int CNT_W     = $clog2(MAX_FRAMES + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pfr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [PAGE_BITS-1:0]               page_number,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [pfr_pkg::OUTCOME_W-1:0]      outcome,
	output logic [SLOT_W-1:0]                  frame_slot,
	output logic [PAGE_BITS-1:0]               evicted_page,
	output logic [pfr_pkg::FAULT_W-1:0]        fault_total
);

	typedef enum logic [2:0] {S_IDLE, S_LOOK, S_DECIDE, S_SWEEP, S_COMMIT} state_t;

	state_t                          state_q;
	logic [1:0]                      mode_q;
	logic [pfr_pkg::CFG_DATA_W-1:0]  frames_cfg_q;
	logic [PAGE_BITS-1:0]            page_q;
	logic                            hit_q;
	logic [SLOT_W-1:0]               hit_slot_q;
	logic [pfr_pkg::OUTCOME_W-1:0]   kind_q;
	logic [CNT_W-1:0]                filled_q;
	logic [pfr_pkg::FAULT_W-1:0]     faults_q;
	logic                            out_valid_q;
	logic [pfr_pkg::OUTCOME_W-1:0]   outcome_q;
	logic [SLOT_W-1:0]               slot_q;
	logic [PAGE_BITS-1:0]            evicted_q;

	pfr_pkg::pfr_cell_ctl_t          ctl;
	pfr_pkg::pfr_cell_sts_t          sts [MAX_FRAMES];
	logic [PAGE_BITS-1:0]            cell_page [MAX_FRAMES];
	logic [SLOT_W-1:0]               cell_rank [MAX_FRAMES];

	logic [MAX_FRAMES-1:0]           match_vec;
	logic [MAX_FRAMES-1:0]           token_vec;
	logic [MAX_FRAMES-1:0]           lru_vec;
	logic [MAX_FRAMES-1:0]           sel_vec;
	logic [MAX_FRAMES-1:0]           home_vec;
	logic                            hit_any;
	logic                            token_ref;
	logic                            home_any;
	logic [SLOT_W-1:0]               hit_idx;
	logic [SLOT_W-1:0]               hand_idx;
	logic [SLOT_W-1:0]               lru_idx;
	logic [31:0]                     limit_wide;
	logic [CNT_W-1:0]                limit;
	logic                            is_lru;
	logic                            is_clock;
	logic                            out_free;
	logic [SLOT_W-1:0]               slot_c;
	logic [SLOT_W-1:0]               old_rank_c;
	logic [SLOT_W-1:0]               sel_rank;
	logic [PAGE_BITS-1:0]            sel_page;
	logic [SLOT_W-1:0]               last_rank;
	logic [CNT_W-1:0]                filled_c;
	logic [CNT_W-1:0]                wrap_c;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= pfr_pkg::MODE_FIFO;
			frames_cfg_q <= pfr_pkg::FRAMES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pfr_pkg::REG_POLICY_MODE:   mode_q       <= cfg_data[1:0];
				pfr_pkg::REG_FRAMES_IN_USE: frames_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// frames in use, clamped to 1..MAX_FRAMES
	always_comb begin
		if (frames_cfg_q == '0) begin
			limit_wide = 32'd1;
		end else if (32'(frames_cfg_q) > 32'(MAX_FRAMES)) begin
			limit_wide = 32'(MAX_FRAMES);
		end else begin
			limit_wide = 32'(frames_cfg_q);
		end
	end
	assign limit = CNT_W'(limit_wide);

	assign is_lru   = (mode_q == pfr_pkg::MODE_LRU);
	assign is_clock = (mode_q == pfr_pkg::MODE_CLOCK);
	assign out_free = !out_valid_q || out_ready;
	assign last_rank = SLOT_W'(filled_q - 1'b1);

	// status gathered from the row
	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			match_vec[i] = sts[i].match;
			token_vec[i] = sts[i].token;
			lru_vec[i]   = sts[i].lru_hit;
			home_vec[i]  = sts[i].give_home;
		end
	end
	assign hit_any   = |match_vec;
	assign home_any  = |home_vec;

	always_comb begin
		token_ref = 1'b0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			token_ref = token_ref | (sts[i].token & sts[i].ref_bit);
		end
	end

	pfr_encode #(.N(MAX_FRAMES), .W(SLOT_W)) u_hit_enc (
		.onehot (match_vec),
		.index  (hit_idx)
	);

	pfr_encode #(.N(MAX_FRAMES), .W(SLOT_W)) u_hand_enc (
		.onehot (token_vec),
		.index  (hand_idx)
	);

	pfr_encode #(.N(MAX_FRAMES), .W(SLOT_W)) u_lru_enc (
		.onehot (lru_vec),
		.index  (lru_idx)
	);

	// frame chosen for the commit step
	always_comb begin
		if (kind_q == pfr_pkg::OUT_HIT) begin
			slot_c = hit_slot_q;
		end else if (kind_q == pfr_pkg::OUT_FILL) begin
			slot_c = SLOT_W'(filled_q);
		end else if (is_lru) begin
			slot_c = lru_idx;
		end else begin
			slot_c = hand_idx;
		end
	end

	always_comb begin
		sel_rank = '0;
		sel_page = '0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			sel_vec[i] = (slot_c == SLOT_W'(i));
			if (sel_vec[i]) begin
				sel_rank = sel_rank | cell_rank[i];
				sel_page = sel_page | cell_page[i];
			end
		end
	end

	// a fill enters as the oldest frame before being touched
	assign old_rank_c = (kind_q == pfr_pkg::OUT_FILL) ? SLOT_W'(filled_q) : sel_rank;

	// controller commands
	always_comb begin
		ctl      = '0;
		filled_c = filled_q;
		wrap_c   = filled_q;
		case (state_q)
			S_DECIDE: begin
				if (!hit_q && !(filled_q < limit)) begin
					ctl.hand_home = 1'b1;
				end
			end
			S_SWEEP: begin
				ctl.sweep = token_ref;
			end
			S_COMMIT: begin
				if (out_free) begin
					ctl.commit = 1'b1;
					ctl.load   = (kind_q != pfr_pkg::OUT_HIT);
					if (kind_q == pfr_pkg::OUT_FILL) begin
						ctl.hand_adv = 1'b1;
						filled_c     = filled_q + 1'b1;
						wrap_c       = limit;
					end else if (kind_q == pfr_pkg::OUT_FAULT) begin
						ctl.hand_adv = !is_lru;
					end
				end
			end
			default: ;
		endcase
	end

	// row of frame cells, the hand token passes from each cell to the next
	for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
		logic from_prev;
		if (g == 0) begin : g_first
			assign from_prev = 1'b0;
		end else begin : g_rest
			assign from_prev = sts[g-1].give_next;
		end

		pfr_cell #(
			.INDEX     (g),
			.PAGE_BITS (PAGE_BITS),
			.SLOT_W    (SLOT_W),
			.CNT_W     (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.page      (page_q),
			.sel       (sel_vec[g]),
			.old_rank  (old_rank_c),
			.last_rank (last_rank),
			.filled    (filled_c),
			.wrap      (wrap_c),
			.from_prev (from_prev),
			.home_any  (home_any),
			.sts       (sts[g]),
			.page_out  (cell_page[g]),
			.rank_out  (cell_rank[g])
		);
	end

	// reference and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			page_q <= page_number;
		end
		if (state_q == S_LOOK) begin
			hit_slot_q <= hit_idx;
		end
		if (state_q == S_COMMIT && out_free) begin
			outcome_q <= kind_q;
			slot_q    <= slot_c;
			evicted_q <= (kind_q == pfr_pkg::OUT_FAULT) ? sel_page : '0;
		end
	end

	// state machine and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hit_q       <= 1'b0;
			kind_q      <= pfr_pkg::OUT_HIT;
			filled_q    <= '0;
			faults_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					hit_q   <= hit_any;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (hit_q) begin
						kind_q  <= pfr_pkg::OUT_HIT;
						state_q <= S_COMMIT;
					end else if (filled_q < limit) begin
						kind_q  <= pfr_pkg::OUT_FILL;
						state_q <= S_COMMIT;
					end else begin
						kind_q  <= pfr_pkg::OUT_FAULT;
						state_q <= is_clock ? S_SWEEP : S_COMMIT;
					end
				end
				S_SWEEP: begin
					// stop once the hand rests on a frame without a second chance
					if (!token_ref) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						filled_q    <= filled_c;
						if (kind_q == pfr_pkg::OUT_FAULT && faults_q != '1) begin
							faults_q <= faults_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign outcome      = outcome_q;
	assign frame_slot   = slot_q;
	assign evicted_page = evicted_q;
	assign fault_total  = faults_q;

endmodule
